/* design/bsd_pkg.sv */
// ----------------------------------------------------------------------------
// Backslash escape decoder package
// Shared types and constants for the escape decoder and its checker.
// ----------------------------------------------------------------------------
package bsd_pkg;

  // Commands held between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ESCAPE_ENABLE  = 1'b0,
    CFG_NEWLINE_ENABLE = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    REQ_DATA      = 2'd0,
    REQ_ARG_END   = 2'd1,
    REQ_FINAL_END = 2'd2,
    REQ_UNUSED    = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_STOP  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // One result without its position marker.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
  } result_t;

  // Everything one input transfer produces: one or two results.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } cmd_t;

endpackage

/* design/bsd_stream_if.sv */
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface bsd_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/bsd_front.sv */
// ----------------------------------------------------------------------------
// Escape decoder front end
// Holds the configuration, accepts input items, tracks the escape parser
// state and turns each item into a command of one or two results, or none.
// ----------------------------------------------------------------------------
module bsd_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bsd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bsd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  bsd_stream_if.sink                         in_i,
  input  logic                               q_full_i,
  output logic                               push_o,
  output bsd_pkg::cmd_t                      cmd_o
);
  import bsd_pkg::*;

  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_BSLASH = 5'b00010,
    MODE_OCTAL  = 5'b00100,
    MODE_HEX    = 5'b01000,
    MODE_HALTED = 5'b10000
  } mode_e;

  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChSeven     = 8'h37;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChLowA      = 8'h61;
  localparam logic [7:0] ChLowF      = 8'h66;
  localparam logic [7:0] ChUpA       = 8'h41;
  localparam logic [7:0] ChUpF       = 8'h46;
  localparam logic [7:0] ChLowX      = 8'h78;
  localparam logic [7:0] ChLowC      = 8'h63;

  logic       esc_en_q, nl_en_q;
  mode_e      mode_q, mode_d;
  logic [7:0] acc_q, acc_d;
  logic [1:0] cnt_q, cnt_d;

  logic       accept;
  logic       is_hex;
  logic       dig_ok;
  logic [3:0] dig_val;
  logic [7:0] acc_next;
  logic [1:0] cnt_next;
  logic       at_limit;
  logic [1:0] n_res;
  result_t    res0, res1;
  logic [7:0] b;

  assign b        = in_i.data.in_byte;
  assign in_i.ready = !q_full_i;
  assign accept   = in_i.valid && !q_full_i;

  // Digit classification for the base of the pending number.
  assign is_hex = (mode_q == MODE_HEX);
  always_comb begin
    dig_ok  = 1'b0;
    dig_val = b[3:0];
    if (b >= ChZero && b <= (is_hex ? ChNine : ChSeven)) begin
      dig_ok = 1'b1;
    end else if (is_hex && ((b >= ChLowA && b <= ChLowF) || (b >= ChUpA && b <= ChUpF))) begin
      // Letters a-f and A-F have low nibbles 1 to 6.
      dig_ok  = 1'b1;
      dig_val = b[3:0] + 4'd9;
    end
  end

  assign acc_next = is_hex ? {acc_q[3:0], dig_val} : {acc_q[4:0], dig_val[2:0]};
  assign cnt_next = cnt_q + 2'd1;
  assign at_limit = is_hex ? (cnt_next >= 2'd2) : (cnt_next >= 2'd3);

  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    n_res  = 2'd0;
    res0   = '{out_byte: b, status: ST_BYTE};
    res1   = '{out_byte: b, status: ST_BYTE};
    if (mode_q != MODE_HALTED && in_i.data.req_type != REQ_UNUSED) begin
      if (in_i.data.req_type == REQ_DATA) begin
        if (!esc_en_q) begin
          mode_d = MODE_NORMAL;
          acc_d  = '0;
          cnt_d  = '0;
          n_res  = 2'd1;
        end else begin
          case (mode_q)
            MODE_BSLASH: begin
              mode_d = MODE_NORMAL;
              n_res  = 2'd1;
              case (b)
                ChBackslash: res0.out_byte = ChBackslash;
                8'h61:       res0.out_byte = 8'd7;   // a
                8'h62:       res0.out_byte = 8'd8;   // b
                8'h65:       res0.out_byte = 8'd27;  // e
                8'h66:       res0.out_byte = 8'd12;  // f
                8'h6e:       res0.out_byte = 8'd10;  // n
                8'h72:       res0.out_byte = 8'd13;  // r
                8'h74:       res0.out_byte = 8'd9;   // t
                8'h76:       res0.out_byte = 8'd11;  // v
                ChLowC: begin
                  mode_d = MODE_HALTED;
                  res0   = '{out_byte: 8'd0, status: ST_STOP};
                end
                ChZero: begin
                  mode_d = MODE_OCTAL;
                  acc_d  = '0;
                  cnt_d  = '0;
                  n_res  = 2'd0;
                end
                ChLowX: begin
                  mode_d = MODE_HEX;
                  acc_d  = '0;
                  cnt_d  = '0;
                  n_res  = 2'd0;
                end
                default: begin
                  mode_d = MODE_HALTED;
                  res0   = '{out_byte: 8'd0, status: ST_ERROR};
                end
              endcase
            end
            MODE_OCTAL, MODE_HEX: begin
              if (!dig_ok) begin
                // Flush the pending value, then take the byte as plain text or a new escape.
                res0.out_byte = acc_q;
                acc_d = '0;
                cnt_d = '0;
                if (b == ChBackslash) begin
                  mode_d = MODE_BSLASH;
                  n_res  = 2'd1;
                end else begin
                  mode_d = MODE_NORMAL;
                  n_res  = 2'd2;
                end
              end else if (at_limit) begin
                res0.out_byte = acc_next;
                n_res  = 2'd1;
                mode_d = MODE_NORMAL;
                acc_d  = '0;
                cnt_d  = '0;
              end else begin
                acc_d = acc_next;
                cnt_d = cnt_next;
              end
            end
            default: begin
              // Normal mode; unused codes behave the same way.
              if (b == ChBackslash) begin
                mode_d = MODE_BSLASH;
              end else begin
                mode_d = MODE_NORMAL;
                n_res  = 2'd1;
              end
            end
          endcase
        end
      end else begin
        // End of an argument: flush a pending number, then a space, or at the final end a newline if enabled.
        logic flush;
        logic sep;
        flush  = esc_en_q && (mode_q == MODE_OCTAL || mode_q == MODE_HEX);
        sep    = (in_i.data.req_type == REQ_ARG_END) || nl_en_q;
        mode_d = MODE_NORMAL;
        acc_d  = '0;
        cnt_d  = '0;
        res0.out_byte = acc_q;
        res1.out_byte = (in_i.data.req_type == REQ_ARG_END) ? ChSpace : ChNewline;
        if (flush && sep) begin
          n_res = 2'd2;
        end else if (flush) begin
          n_res = 2'd1;
        end else if (sep) begin
          n_res = 2'd1;
          res0  = res1;
        end
      end
    end
  end

  assign push_o       = accept && (n_res != 2'd0);
  assign cmd_o.two    = (n_res == 2'd2);
  assign cmd_o.first  = res0;
  assign cmd_o.second = res1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_en_q <= 1'b0;
      nl_en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ESCAPE_ENABLE) begin
        esc_en_q <= cfg_data_i[0];
      end
      if (cfg_idx_i == CFG_NEWLINE_ENABLE) begin
        nl_en_q <= cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      acc_q  <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* design/bsd_cmd_queue.sv */
// ----------------------------------------------------------------------------
// Escape decoder command queue
// Small register FIFO that decouples the front end from the output side.
// ----------------------------------------------------------------------------
module bsd_cmd_queue #(
  parameter int unsigned QueueDepth = bsd_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bsd_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bsd_pkg::cmd_t head_o
);
  import bsd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

/* design/bsd_back.sv */
// ----------------------------------------------------------------------------
// Escape decoder back end
// Unpacks queued commands into single results and drives the registered
// output channel, marking the last result of each command.
// ----------------------------------------------------------------------------
module bsd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  bsd_pkg::cmd_t q_head_i,
  output logic          q_pop_o,
  bsd_stream_if.source  out_o
);
  import bsd_pkg::*;

  logic      out_valid_q;
  out_item_t out_data_q, out_data_d;
  logic      second_q, second_d;
  logic      load;

  // The output register takes a new result when empty or being drained.
  assign load = q_valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    second_d = second_q;
    q_pop_o  = 1'b0;
    if (second_q) begin
      out_data_d = '{out_byte: q_head_i.second.out_byte,
                     status:   q_head_i.second.status,
                     last:     1'b1};
    end else begin
      out_data_d = '{out_byte: q_head_i.first.out_byte,
                     status:   q_head_i.first.status,
                     last:     !q_head_i.two};
    end
    if (load) begin
      if (!second_q && q_head_i.two) begin
        second_d = 1'b1;
      end else begin
        second_d = 1'b0;
        q_pop_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      second_q <= second_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

/* design/backslash_escape_decoder_unit.sv */
// ----------------------------------------------------------------------------
// Backslash escape decoder unit
// Echo-style output stage: streams argument bytes, decodes backslash escapes
// and emits output bytes, separators and stop or error markers.
// ----------------------------------------------------------------------------
// The unit takes one input item per cycle while the queue has room. The front
// end decodes each item in the cycle of its transfer and, if it yields a
// result, pushes a command into a queue of QueueDepth entries; the back end
// turns each command into one or two results through a registered output,
// one result per cycle while the output is taken; a first result passes the
// queue entry and then the output register. Items with two results (a flushed
// octal or hex value and then a byte or separator) hold the output for both,
// and a steady stream of them fills the queue and stalls input. Configuration
// writes take effect on the next cycle and belong in idle periods only.
module backslash_escape_decoder_unit #(
  parameter int unsigned QueueDepth = bsd_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bsd_stream_if.sink                     in_i,
  bsd_stream_if.source                   out_o
);
  import bsd_pkg::*;

  logic push, q_full, q_valid, q_pop;
  cmd_t push_cmd, q_head;

  bsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  bsd_cmd_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  bsd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

/* design/bsd_checker.sv */
// ----------------------------------------------------------------------------
// Escape decoder port checker
// Concurrent checks on the unit's channel ports, bound to the top level.
// ----------------------------------------------------------------------------
module bsd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input bsd_pkg::out_item_t out_item_i
);
  import bsd_pkg::*;

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("output result changed while stalled");

  // Stop and error markers carry a zero byte and close their item.
  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.status != ST_BYTE |-> out_item_i.last && out_item_i.out_byte == 8'd0)
    else $error("stop or error marker malformed");

  // After a stop or error marker the unit is halted and shows nothing more.
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_item_i.status != ST_BYTE |=> !out_valid_i)
    else $error("output after halt");

  // An idle output only wakes up after an input transfer has passed the queue and the output register.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !$past(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a preceding input transfer");

endmodule

bind backslash_escape_decoder_unit bsd_checker u_bsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.data)
);
